// ----- src/prdg_pkg.sv -----
// ----------------------------------------------------------------------------
// prdg_pkg: shared constants for the primary ray direction generator
// Field widths, configuration register indexes, reset values and the
// fixed-point sizes used by the normalization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package prdg_pkg;

  localparam int PIXEL_INDEX_BITS_DEF = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_BASIS_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd7;

  // Field widths.
  localparam int BASIS_W = 48;
  localparam int COMP_W  = 16;
  localparam int PLANE_W = 16;
  localparam int COUNT_W = 13;
  localparam int DIR_W   = 16;

  // Reset values.
  localparam logic [BASIS_W-1:0] BASIS_U_RST = 48'h0000_0000_4000;
  localparam logic [BASIS_W-1:0] BASIS_V_RST = 48'h0000_4000_0000;
  localparam logic [BASIS_W-1:0] BASIS_W_RST = 48'h4000_0000_0000;
  localparam logic [PLANE_W-1:0] FOCAL_RST   = 16'd256;
  localparam logic [PLANE_W-1:0] WIDTH_RST   = 16'd512;
  localparam logic [PLANE_W-1:0] HEIGHT_RST  = 16'd512;
  localparam logic [COUNT_W-1:0] COLUMNS_RST = 13'd640;
  localparam logic [COUNT_W-1:0] ROWS_RST    = 13'd480;

  // Normalization sizes: magnitudes are brought below 2^30, the root of the
  // sum of three squares fits 31 bits, and a unit component needs 15 bits.
  localparam int MAG_W   = 30;
  localparam int ROOT_W  = 31;
  localparam int FRAC_W  = 14;
  localparam int UNIT_QW = 15;
  localparam logic [UNIT_QW-1:0] UNIT_ONE = 15'd16384;

endpackage

`default_nettype wire

// ----- src/prdg_div_pipe.sv -----
// ----------------------------------------------------------------------------
// prdg_div_pipe: pipelined restoring divider
// One quotient bit per register stage. The dividend must be below the
// divisor times 2^QW; an item may enter each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_div_pipe #(
  parameter int QW    = 15,
  parameter int DW    = 31,
  parameter int TAG_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [QW+DW-1:0]    in_num,
  input  wire logic [DW-1:0]       in_den,
  input  wire logic [TAG_W-1:0]    in_tag,
  output      logic                out_valid,
  output      logic [QW-1:0]       out_quo,
  output      logic [TAG_W-1:0]    out_tag
);

  logic              valid_r [1:QW];
  logic [DW-1:0]     rem_r   [1:QW];
  logic [QW-1:0]     low_r   [1:QW];
  logic [DW-1:0]     den_r   [1:QW];
  logic [TAG_W-1:0]  tag_r   [1:QW];

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic              src_valid;
    logic [DW-1:0]     src_rem;
    logic [QW-1:0]     src_low;
    logic [DW-1:0]     src_den;
    logic [TAG_W-1:0]  src_tag;
    logic [DW:0]       trial;
    logic              ge;

    if (k == 1) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_num[QW+DW-1:QW];
      assign src_low   = in_num[QW-1:0];
      assign src_den   = in_den;
      assign src_tag   = in_tag;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_low   = low_r[k-1];
      assign src_den   = den_r[k-1];
      assign src_tag   = tag_r[k-1];
    end

    assign trial = {src_rem, src_low[QW-1]};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
      low_r[k] <= {src_low[QW-2:0], ge};
      den_r[k] <= src_den;
      tag_r[k] <= src_tag;
    end
  end

  assign out_valid = valid_r[QW];
  assign out_quo   = low_r[QW];
  assign out_tag   = tag_r[QW];

endmodule

`default_nettype wire

// ----- src/prdg_isqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// prdg_isqrt_pipe: pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// An item may enter each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_isqrt_pipe #(
  parameter int ROOT_W = 31,
  parameter int TAG_W  = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   in_rad,
  input  wire logic [TAG_W-1:0]      in_tag,
  output      logic                  out_valid,
  output      logic [ROOT_W-1:0]     out_root,
  output      logic [TAG_W-1:0]      out_tag
);

  localparam int RW = 2 * ROOT_W;

  logic              valid_r [1:ROOT_W];
  logic [RW-1:0]     rem_r   [1:ROOT_W];
  logic [RW-1:0]     res_r   [1:ROOT_W];
  logic [TAG_W-1:0]  tag_r   [1:ROOT_W];

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    localparam logic [RW-1:0] BIT_V = RW'(1) << (2 * (ROOT_W - k));

    logic              src_valid;
    logic [RW-1:0]     src_rem;
    logic [RW-1:0]     src_res;
    logic [TAG_W-1:0]  src_tag;
    logic [RW:0]       trial;
    logic              ge;

    if (k == 1) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_rad;
      assign src_res   = '0;
      assign src_tag   = in_tag;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_res   = res_r[k-1];
      assign src_tag   = tag_r[k-1];
    end

    assign trial = {1'b0, src_res} + {1'b0, BIT_V};
    assign ge    = ({1'b0, src_rem} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? RW'({1'b0, src_rem} - trial) : src_rem;
      res_r[k] <= ge ? ((src_res >> 1) + BIT_V) : (src_res >> 1);
      tag_r[k] <= src_tag;
    end
  end

  assign out_valid = valid_r[ROOT_W];
  assign out_root  = res_r[ROOT_W][ROOT_W-1:0];
  assign out_tag   = tag_r[ROOT_W];

endmodule

`default_nettype wire

// ----- src/primary_ray_direction_generator_core.sv -----
// ----------------------------------------------------------------------------
// primary_ray_direction_generator_core: pinhole camera primary ray directions
// For each pixel the unit direction through the pixel center is formed as
// -focal*w + su*u + sv*v and normalized to Q2.14.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------------
//  input     start & !busy          in_pixel_column, in_pixel_row
//  result    out_valid (strobe)     out_dir_x, out_dir_y, out_dir_z (Q2.14)
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
// The block is a straight pipeline with a valid bit in every stage, so an item
// is taken in every cycle and busy stays low. Between the edge that accepts an
// item and its out_valid strobe lie two input stages, the bit-per-stage offset
// divider (max(PIXEL_INDEX_BITS, 12) + 26 stages), eight product, shift and
// square stages, the 31-stage square root, one rounding stage, the 15-stage
// normalizing divider and the output register.
// Reset is synchronous and active low; it clears the valid bits and loads the
// configuration reset values. Results cannot be held off, so nothing stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module primary_ray_direction_generator_core #(
  parameter int PIXEL_INDEX_BITS = prdg_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input items.
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [PIXEL_INDEX_BITS-1:0]         in_pixel_column,
  input  wire logic [PIXEL_INDEX_BITS-1:0]         in_pixel_row,
  // Configuration writes.
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [prdg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [prdg_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Result items.
  output      logic                                out_valid,
  output      logic signed [prdg_pkg::DIR_W-1:0]   out_dir_x,
  output      logic signed [prdg_pkg::DIR_W-1:0]   out_dir_y,
  output      logic signed [prdg_pkg::DIR_W-1:0]   out_dir_z
);

  localparam int COMP_W  = prdg_pkg::COMP_W;
  localparam int PLANE_W = prdg_pkg::PLANE_W;
  localparam int COUNT_W = prdg_pkg::COUNT_W;
  localparam int MAG_W   = prdg_pkg::MAG_W;
  localparam int ROOT_W  = prdg_pkg::ROOT_W;
  localparam int FRAC_W  = prdg_pkg::FRAC_W;
  localparam int UNIT_QW = prdg_pkg::UNIT_QW;
  localparam int DIR_W   = prdg_pkg::DIR_W;

  // Magnitude of 2*index + 1 - count; the count alone may use all COUNT_W bits.
  localparam int NUM_MAG_W = (PIXEL_INDEX_BITS + 1 > COUNT_W) ?
                             PIXEL_INDEX_BITS + 1 : COUNT_W;
  localparam int NUM_S_W   = NUM_MAG_W + 2;
  localparam int PROD_W    = NUM_MAG_W + PLANE_W;
  // Offset dividend: size*|num|*256 + count.
  localparam int OFF_QW    = PROD_W + 8 + 1;
  localparam int DEN_W     = COUNT_W + 1;
  localparam int SU_W      = OFF_QW + 1;
  localparam int TERM_W    = SU_W + COMP_W;
  localparam int FW_W      = PLANE_W + 1 + COMP_W;
  localparam int D_W       = TERM_W + 2;
  localparam int SHIFT_W   = $clog2(D_W + 1);
  localparam int SQ_W      = 2 * MAG_W;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_TAG_W  = 3 * (MAG_W + 1);
  localparam int NRM_N_W   = UNIT_QW + ROOT_W;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline
  // is empty; the block does not enforce it. Every stage reads them directly.
  // --------------------------------------------------------------------------
  logic [prdg_pkg::BASIS_W-1:0] basis_u_r, basis_v_r, basis_w_r;
  logic [PLANE_W-1:0]           focal_r, width_r, height_r;
  logic [COUNT_W-1:0]           columns_r, rows_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_u_r <= prdg_pkg::BASIS_U_RST;
      basis_v_r <= prdg_pkg::BASIS_V_RST;
      basis_w_r <= prdg_pkg::BASIS_W_RST;
      focal_r   <= prdg_pkg::FOCAL_RST;
      width_r   <= prdg_pkg::WIDTH_RST;
      height_r  <= prdg_pkg::HEIGHT_RST;
      columns_r <= prdg_pkg::COLUMNS_RST;
      rows_r    <= prdg_pkg::ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prdg_pkg::REG_BASIS_U: basis_u_r <= cfg_data[prdg_pkg::BASIS_W-1:0];
        prdg_pkg::REG_BASIS_V: basis_v_r <= cfg_data[prdg_pkg::BASIS_W-1:0];
        prdg_pkg::REG_BASIS_W: basis_w_r <= cfg_data[prdg_pkg::BASIS_W-1:0];
        prdg_pkg::REG_FOCAL:   focal_r   <= cfg_data[PLANE_W-1:0];
        prdg_pkg::REG_WIDTH:   width_r   <= cfg_data[PLANE_W-1:0];
        prdg_pkg::REG_HEIGHT:  height_r  <= cfg_data[PLANE_W-1:0];
        prdg_pkg::REG_COLUMNS: columns_r <= cfg_data[COUNT_W-1:0];
        prdg_pkg::REG_ROWS:    rows_r    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A pixel count of zero behaves as one.
  logic [COUNT_W-1:0] cols_eff, rows_eff;
  assign cols_eff = (columns_r == '0) ? COUNT_W'(1) : columns_r;
  assign rows_eff = (rows_r == '0) ? COUNT_W'(1) : rows_r;

  // Basis components, x in the low 16 bits.
  logic signed [COMP_W-1:0] u_c [3];
  logic signed [COMP_W-1:0] v_c [3];
  logic signed [COMP_W-1:0] w_c [3];

  for (genvar i = 0; i < 3; i++) begin : g_comp
    assign u_c[i] = $signed(basis_u_r[COMP_W*i +: COMP_W]);
    assign v_c[i] = $signed(basis_v_r[COMP_W*i +: COMP_W]);
    assign w_c[i] = $signed(basis_w_r[COMP_W*i +: COMP_W]);
  end

  // --------------------------------------------------------------------------
  // Stage 0: signed numerators 2c+1-columns and rows-2r-1, split into sign
  // and magnitude.
  // --------------------------------------------------------------------------
  logic signed [NUM_S_W-1:0] num_c, num_r;
  logic                      s0_valid_r;
  logic [NUM_MAG_W-1:0]      s0_cmag_r, s0_rmag_r;
  logic                      s0_cneg_r, s0_rneg_r;

  assign num_c = $signed(NUM_S_W'({in_pixel_column, 1'b1})) - $signed(NUM_S_W'(cols_eff));
  assign num_r = $signed(NUM_S_W'(rows_eff)) - $signed(NUM_S_W'({in_pixel_row, 1'b1}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_cneg_r <= num_c[NUM_S_W-1];
    s0_rneg_r <= num_r[NUM_S_W-1];
    s0_cmag_r <= num_c[NUM_S_W-1] ? NUM_MAG_W'(-num_c) : NUM_MAG_W'(num_c);
    s0_rmag_r <= num_r[NUM_S_W-1] ? NUM_MAG_W'(-num_r) : NUM_MAG_W'(num_r);
  end

  // --------------------------------------------------------------------------
  // Stage 1: offset dividends size*|num|*256 + count. Adding the count before
  // dividing by twice the count rounds half away from zero on the magnitude.
  // --------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [OFF_QW-1:0]     s1_cnum_r, s1_rnum_r;
  logic                  s1_cneg_r, s1_rneg_r;
  logic [PROD_W-1:0]     cprod, rprod;

  assign cprod = PROD_W'(s0_cmag_r) * PROD_W'(width_r);
  assign rprod = PROD_W'(s0_rmag_r) * PROD_W'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_cnum_r <= OFF_QW'({cprod, 8'd0}) + OFF_QW'(cols_eff);
    s1_rnum_r <= OFF_QW'({rprod, 8'd0}) + OFF_QW'(rows_eff);
    s1_cneg_r <= s0_cneg_r;
    s1_rneg_r <= s0_rneg_r;
  end

  // --------------------------------------------------------------------------
  // Offset dividers: su and sv magnitudes in units of 2^-16.
  // --------------------------------------------------------------------------
  logic              su_valid;
  logic [OFF_QW-1:0] su_quo, sv_quo;
  logic              su_neg, sv_neg;

  prdg_div_pipe #(
    .QW    (OFF_QW),
    .DW    (DEN_W),
    .TAG_W (1)
  ) u_div_su (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_num    ({DEN_W'(0), s1_cnum_r}),
    .in_den    ({cols_eff, 1'b0}),
    .in_tag    (s1_cneg_r),
    .out_valid (su_valid),
    .out_quo   (su_quo),
    .out_tag   (su_neg)
  );

  prdg_div_pipe #(
    .QW    (OFF_QW),
    .DW    (DEN_W),
    .TAG_W (1)
  ) u_div_sv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_num    ({DEN_W'(0), s1_rnum_r}),
    .in_den    ({rows_eff, 1'b0}),
    .in_tag    (s1_rneg_r),
    .out_valid (),
    .out_quo   (sv_quo),
    .out_tag   (sv_neg)
  );

  // --------------------------------------------------------------------------
  // Stage P: apply the signs of the offsets.
  // --------------------------------------------------------------------------
  logic                   sp_valid_r;
  logic signed [SU_W-1:0] sp_su_r, sp_sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_valid_r <= 1'b0;
    end else begin
      sp_valid_r <= su_valid;
    end
  end

  always_ff @(posedge clk) begin
    sp_su_r <= su_neg ? -$signed(SU_W'(su_quo)) : $signed(SU_W'(su_quo));
    sp_sv_r <= sv_neg ? -$signed(SU_W'(sv_quo)) : $signed(SU_W'(sv_quo));
  end

  // --------------------------------------------------------------------------
  // Stage M: the nine basis products. Stage A: sum per component, in units
  // of 2^-30.
  // --------------------------------------------------------------------------
  logic                     sm_valid_r, sa_valid_r;
  logic signed [FW_W-1:0]   sm_fw_r [3];
  logic signed [TERM_W-1:0] sm_pu_r [3];
  logic signed [TERM_W-1:0] sm_pv_r [3];
  logic signed [D_W-1:0]    sa_d_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_valid_r <= 1'b0;
      sa_valid_r <= 1'b0;
    end else begin
      sm_valid_r <= sp_valid_r;
      sa_valid_r <= sm_valid_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dir
    always_ff @(posedge clk) begin
      sm_fw_r[i] <= FW_W'($signed({1'b0, focal_r})) * FW_W'(w_c[i]);
      sm_pu_r[i] <= TERM_W'(sp_su_r) * TERM_W'(u_c[i]);
      sm_pv_r[i] <= TERM_W'(sp_sv_r) * TERM_W'(v_c[i]);
      sa_d_r[i]  <= D_W'(sm_pu_r[i]) + D_W'(sm_pv_r[i]) - (D_W'(sm_fw_r[i]) <<< 8);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: sign and magnitude. Stage C: right shift that brings the largest
  // magnitude below 2^30, found from the OR of the three magnitudes.
  // Stage D: apply the shift.
  // --------------------------------------------------------------------------
  logic                 sb_valid_r, sc_valid_r, sd_valid_r;
  logic [D_W-1:0]       sb_mag_r [3];
  logic [2:0]           sb_neg_r, sc_neg_r, sd_neg_r;
  logic [D_W-1:0]       sc_mag_r [3];
  logic [SHIFT_W-1:0]   sc_shift_r;
  logic [MAG_W-1:0]     sd_mag_r [3];
  logic [D_W-1:0]       mag_or;
  logic [SHIFT_W-1:0]   shift_nxt;

  assign mag_or = sb_mag_r[0] | sb_mag_r[1] | sb_mag_r[2];

  always_comb begin
    shift_nxt = '0;
    for (int b = MAG_W; b < D_W; b++) begin
      if (mag_or[b]) begin
        shift_nxt = SHIFT_W'(b - MAG_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
      sc_valid_r <= 1'b0;
      sd_valid_r <= 1'b0;
    end else begin
      sb_valid_r <= sa_valid_r;
      sc_valid_r <= sb_valid_r;
      sd_valid_r <= sc_valid_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mag
    always_ff @(posedge clk) begin
      sb_neg_r[i] <= sa_d_r[i][D_W-1];
      sb_mag_r[i] <= sa_d_r[i][D_W-1] ? D_W'(-sa_d_r[i]) : D_W'(sa_d_r[i]);
      sc_mag_r[i] <= sb_mag_r[i];
      sd_mag_r[i] <= MAG_W'(sc_mag_r[i] >> sc_shift_r);
    end
  end

  always_ff @(posedge clk) begin
    sc_neg_r   <= sb_neg_r;
    sc_shift_r <= shift_nxt;
    sd_neg_r   <= sc_neg_r;
  end

  // --------------------------------------------------------------------------
  // Stage E: squares. Stage F: their sum, which feeds the square root.
  // --------------------------------------------------------------------------
  logic              se_valid_r, sf_valid_r;
  logic [SQ_W-1:0]   se_sq_r  [3];
  logic [MAG_W-1:0]  se_mag_r [3];
  logic [2:0]        se_neg_r, sf_neg_r;
  logic [RAD_W-1:0]  sf_sum_r;
  logic [MAG_W-1:0]  sf_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_valid_r <= 1'b0;
      sf_valid_r <= 1'b0;
    end else begin
      se_valid_r <= sd_valid_r;
      sf_valid_r <= se_valid_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      se_sq_r[i]  <= SQ_W'(sd_mag_r[i]) * SQ_W'(sd_mag_r[i]);
      se_mag_r[i] <= sd_mag_r[i];
      sf_mag_r[i] <= se_mag_r[i];
    end
  end

  always_ff @(posedge clk) begin
    se_neg_r <= sd_neg_r;
    sf_neg_r <= se_neg_r;
    sf_sum_r <= RAD_W'(se_sq_r[0]) + RAD_W'(se_sq_r[1]) + RAD_W'(se_sq_r[2]);
  end

  // --------------------------------------------------------------------------
  // Length: floor of the square root, with the magnitudes and signs carried.
  // --------------------------------------------------------------------------
  logic                 len_valid;
  logic [ROOT_W-1:0]    len;
  logic [SQ_TAG_W-1:0]  len_tag;

  prdg_isqrt_pipe #(
    .ROOT_W (ROOT_W),
    .TAG_W  (SQ_TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sf_valid_r),
    .in_rad    (sf_sum_r),
    .in_tag    ({sf_neg_r, sf_mag_r[2], sf_mag_r[1], sf_mag_r[0]}),
    .out_valid (len_valid),
    .out_root  (len),
    .out_tag   (len_tag)
  );

  // --------------------------------------------------------------------------
  // Stage G: rounded numerators m*2^14 + len/2. The three normalizing
  // dividers then give each component; a zero length is flagged to the end.
  // --------------------------------------------------------------------------
  logic                sg_valid_r;
  logic [NRM_N_W-1:0]  sg_num_r [3];
  logic [ROOT_W-1:0]   sg_len_r;
  logic [2:0]          sg_neg_r;
  logic                sg_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_valid_r <= 1'b0;
    end else begin
      sg_valid_r <= len_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    always_ff @(posedge clk) begin
      sg_num_r[i] <= NRM_N_W'({len_tag[MAG_W*i +: MAG_W], FRAC_W'(0)})
                   + NRM_N_W'(len[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    sg_len_r  <= len;
    sg_neg_r  <= len_tag[SQ_TAG_W-1 -: 3];
    sg_zero_r <= (len == '0);
  end

  logic               nrm_valid;
  logic [UNIT_QW-1:0] nrm_quo  [3];
  logic [1:0]         nrm_tag  [3];

  for (genvar i = 0; i < 3; i++) begin : g_nrm
    if (i == 0) begin : g_lead
      prdg_div_pipe #(
        .QW    (UNIT_QW),
        .DW    (ROOT_W),
        .TAG_W (2)
      ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sg_valid_r),
        .in_num    (sg_num_r[i]),
        .in_den    (sg_len_r),
        .in_tag    ({sg_zero_r, sg_neg_r[i]}),
        .out_valid (nrm_valid),
        .out_quo   (nrm_quo[i]),
        .out_tag   (nrm_tag[i])
      );
    end else begin : g_side
      prdg_div_pipe #(
        .QW    (UNIT_QW),
        .DW    (ROOT_W),
        .TAG_W (2)
      ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sg_valid_r),
        .in_num    (sg_num_r[i]),
        .in_den    (sg_len_r),
        .in_tag    ({sg_zero_r, sg_neg_r[i]}),
        .out_valid (),
        .out_quo   (nrm_quo[i]),
        .out_tag   (nrm_tag[i])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: clamp to one, force zero for a zero-length vector, apply sign.
  // --------------------------------------------------------------------------
  logic                     out_valid_r;
  logic signed [DIR_W-1:0]  dir_r [3];
  logic [UNIT_QW-1:0]       unit_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    always_comb begin
      if (nrm_tag[i][1]) begin
        unit_q[i] = '0;
      end else if (nrm_quo[i] > prdg_pkg::UNIT_ONE) begin
        unit_q[i] = prdg_pkg::UNIT_ONE;
      end else begin
        unit_q[i] = nrm_quo[i];
      end
    end

    always_ff @(posedge clk) begin
      dir_r[i] <= nrm_tag[i][0] ? -$signed(DIR_W'(unit_q[i])) : $signed(DIR_W'(unit_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= nrm_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_r[0];
  assign out_dir_y = dir_r[1];
  assign out_dir_z = dir_r[2];

endmodule

`default_nettype wire

// ----- bench/primary_ray_direction_generator_core_test.sv -----
// ----------------------------------------------------------------------------
// primary_ray_direction_generator_core_test: pixel to ray direction check
// Drives pixel items through the core under several camera setups, predicts
// every unit direction with a fixed-point camera model kept in the bench and
// compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module primary_ray_direction_generator_core_test;

  localparam int PIX_W      = prdg_pkg::PIXEL_INDEX_BITS_DEF;
  localparam int DIR_W      = prdg_pkg::DIR_W;
  localparam int CFG_IDX_W  = prdg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = prdg_pkg::CFG_DATA_W;
  localparam int BASIS_W    = prdg_pkg::BASIS_W;
  localparam int COMP_W     = prdg_pkg::COMP_W;
  localparam int PLANE_W    = prdg_pkg::PLANE_W;
  localparam int COUNT_W    = prdg_pkg::COUNT_W;
  localparam int LATENCY    = ((PIX_W > 12) ? PIX_W : 12) + 83;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } ray_dir_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [PIX_W-1:0] in_pixel_column;
  logic [PIX_W-1:0] in_pixel_row;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic out_valid;
  logic signed [DIR_W-1:0] out_dir_x;
  logic signed [DIR_W-1:0] out_dir_y;
  logic signed [DIR_W-1:0] out_dir_z;

  primary_ray_direction_generator_core #(.PIXEL_INDEX_BITS(PIX_W)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_pixel_column(in_pixel_column), .in_pixel_row(in_pixel_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  // The camera as the bench believes it is programmed. These copies change
  // only when a register write is accepted, and only while the core is idle.
  logic [BASIS_W-1:0] cam_u, cam_v, cam_w;
  logic [PLANE_W-1:0] cam_focal, cam_width, cam_height;
  logic [COUNT_W-1:0] cam_columns, cam_rows;

  pixel_t   pixels_to_send[$];
  ray_dir_t rays_expected[$];
  int       fail_count;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Signed Q2.14 component i of a packed basis vector.
  function automatic longint basis_comp(logic [BASIS_W-1:0] packed_vec, int i);
    logic signed [COMP_W-1:0] c;
    c = packed_vec[COMP_W*i +: COMP_W];
    return longint'(c);
  endfunction

  // Pixel center offset on the image plane, size*num/(2*count), in units of
  // 2^-16, rounded half away from zero.
  function automatic longint plane_offset(longint size, longint num, longint count);
    longint mag;
    longint q;
    mag = (num < 0 ? -num : num) * size * 256;
    q = (mag + count) / (2 * count);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit direction of the primary ray through a pixel center under the
  // current camera setup.
  function automatic ray_dir_t predict_ray(pixel_t px);
    longint cols, rws, su, sv, d;
    longint unsigned mag[3];
    longint unsigned biggest, sum, len, q;
    logic neg[3];
    logic [DIR_W-1:0] res[3];
    int shift;
    ray_dir_t ray;
    // A pixel count of zero behaves as a single pixel.
    cols = (cam_columns == 0) ? 1 : longint'(cam_columns);
    rws  = (cam_rows == 0) ? 1 : longint'(cam_rows);
    su = plane_offset(longint'(cam_width), 2 * longint'(px.column) + 1 - cols, cols);
    sv = plane_offset(longint'(cam_height), rws - 2 * longint'(px.row) - 1, rws);
    biggest = 0;
    for (int i = 0; i < 3; i++) begin
      d = -(longint'(cam_focal) * basis_comp(cam_w, i)) * 256
          + su * basis_comp(cam_u, i) + sv * basis_comp(cam_v, i);
      neg[i] = d < 0;
      mag[i] = neg[i] ? longint'(-d) : longint'(d);
      if (mag[i] > biggest) biggest = mag[i];
    end
    // Bring all magnitudes below 2^30 with one common truncating shift.
    shift = 0;
    while ((biggest >> shift) >= (64'd1 << 30)) shift++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> shift;
      sum = sum + mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      // A zero-length vector gives an all-zero direction.
      if (len != 0) begin
        q = (mag[i] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
      end
      res[i] = neg[i] ? -q[DIR_W-1:0] : q[DIR_W-1:0];
    end
    ray.x = res[0];
    ray.y = res[1];
    ray.z = res[2];
    return ray;
  endfunction

  // Driver: feeds queued pixels, with a random gap before each item. Bursts
  // with no gap at all alternate with gappy stretches.
  int gap_left;
  int sent_count;
  logic burst_mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_pixel_column <= '0;
      in_pixel_row <= '0;
      gap_left <= 0;
      sent_count <= 0;
      burst_mode <= 1'b0;
    end else begin
      automatic int gap = gap_left;
      if (start && !busy) begin
        rays_expected.push_back(predict_ray({in_pixel_column, in_pixel_row}));
        sent_count <= sent_count + 1;
        if (sent_count % 64 == 63) burst_mode <= $urandom_range(0, 2) == 0;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          start <= 1'b0;
          gap = gap - 1;
        end else if (pixels_to_send.size() != 0) begin
          automatic pixel_t px = pixels_to_send.pop_front();
          start <= 1'b1;
          in_pixel_column <= px.column;
          in_pixel_row <= px.row;
        end else begin
          start <= 1'b0;
        end
      end
      gap_left <= gap;
    end
  end

  task automatic check_field(string name, logic signed [DIR_W-1:0] expv,
                             logic signed [DIR_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rays_expected.size() == 0) begin
        $error("unexpected result item: %0d %0d %0d", out_dir_x, out_dir_y, out_dir_z);
        fail_count++;
      end else begin
        automatic ray_dir_t ray = rays_expected.pop_front();
        check_field("dir_x", ray.x, out_dir_x);
        check_field("dir_y", ray.y, out_dir_y);
        check_field("dir_z", ray.z, out_dir_z);
      end
    end
  end

  // Watchdog: too many cycles with no handshake of any kind ends the run.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; the bench copy follows when the write is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      prdg_pkg::REG_BASIS_U: cam_u = data[BASIS_W-1:0];
      prdg_pkg::REG_BASIS_V: cam_v = data[BASIS_W-1:0];
      prdg_pkg::REG_BASIS_W: cam_w = data[BASIS_W-1:0];
      prdg_pkg::REG_FOCAL:   cam_focal = data[PLANE_W-1:0];
      prdg_pkg::REG_WIDTH:   cam_width = data[PLANE_W-1:0];
      prdg_pkg::REG_HEIGHT:  cam_height = data[PLANE_W-1:0];
      prdg_pkg::REG_COLUMNS: cam_columns = data[COUNT_W-1:0];
      prdg_pkg::REG_ROWS:    cam_rows = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_data();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // Random data whose low bits hold the given value, so that unused upper
  // bits of narrow registers get exercised too.
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = rand_data();
    return (junk & ~((48'd1 << w) - 1)) | v;
  endfunction

  task automatic set_camera(logic [BASIS_W-1:0] u, logic [BASIS_W-1:0] v,
                            logic [BASIS_W-1:0] w, logic [PLANE_W-1:0] focal,
                            logic [PLANE_W-1:0] wid, logic [PLANE_W-1:0] hgt,
                            logic [COUNT_W-1:0] cols, logic [COUNT_W-1:0] rws);
    write_reg(prdg_pkg::REG_BASIS_U, u);
    write_reg(prdg_pkg::REG_BASIS_V, v);
    write_reg(prdg_pkg::REG_BASIS_W, w);
    write_reg(prdg_pkg::REG_FOCAL, with_junk(CFG_DATA_W'(focal), PLANE_W));
    write_reg(prdg_pkg::REG_WIDTH, with_junk(CFG_DATA_W'(wid), PLANE_W));
    write_reg(prdg_pkg::REG_HEIGHT, with_junk(CFG_DATA_W'(hgt), PLANE_W));
    write_reg(prdg_pkg::REG_COLUMNS, with_junk(CFG_DATA_W'(cols), COUNT_W));
    write_reg(prdg_pkg::REG_ROWS, with_junk(CFG_DATA_W'(rws), COUNT_W));
  endtask

  task automatic queue_pixel(int c, int r);
    pixel_t px;
    px.column = PIX_W'(c);
    px.row = PIX_W'(r);
    @(negedge clk);
    pixels_to_send.push_back(px);
  endtask

  // Mostly pixels inside the image; the rest anywhere in the index range.
  task automatic queue_random_pixels(int n);
    int cmax, rmax;
    cmax = (cam_columns == '0) ? 0 :
           ((cam_columns > 13'd4096) ? 4095 : int'(cam_columns) - 1);
    rmax = (cam_rows == '0) ? 0 :
           ((cam_rows > 13'd4096) ? 4095 : int'(cam_rows) - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) queue_pixel($urandom_range(0, cmax), $urandom_range(0, rmax));
      else queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  // Waits until every queued pixel has gone in and its ray has come out.
  task automatic drain();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || rays_expected.size() != 0 || start);
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    // Mostly moderate components, sometimes the extremes of Q2.14.
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return COMP_W'($urandom_range(0, 32767) - 16384);
    endcase
  endfunction

  function automatic logic [BASIS_W-1:0] rand_basis();
    if ($urandom_range(0, 3) == 0) return rand_data();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cam_u = prdg_pkg::BASIS_U_RST;
    cam_v = prdg_pkg::BASIS_V_RST;
    cam_w = prdg_pkg::BASIS_W_RST;
    cam_focal = prdg_pkg::FOCAL_RST;
    cam_width = prdg_pkg::WIDTH_RST;
    cam_height = prdg_pkg::HEIGHT_RST;
    cam_columns = prdg_pkg::COLUMNS_RST;
    cam_rows = prdg_pkg::ROWS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset camera: corners, center, far outside.
    queue_pixel(0, 0);
    queue_pixel(639, 479);
    queue_pixel(320, 240);
    queue_pixel(319, 239);
    queue_pixel(0, 479);
    queue_pixel(639, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(2730, 1365);
    drain();

    // A zero basis gives a zero-length vector.
    set_camera('0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd1, 13'd1);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // Zero pixel counts act as one; the most negative components and the
    // largest plane sizes push the normalization shift hardest.
    set_camera({3{16'h8000}}, {3{16'h7FFF}}, {16'h8000, 16'h7FFF, 16'h8000},
               16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd0, 13'd0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(2048, 1);
    drain();

    // Zero focal length with zero and extreme plane sizes, largest pixel counts.
    set_camera(prdg_pkg::BASIS_U_RST, prdg_pkg::BASIS_V_RST, prdg_pkg::BASIS_W_RST,
               16'd0, 16'd0, 16'd0, 13'h1FFF, 13'd4096);
    queue_pixel(0, 0);
    queue_pixel(4095, 2048);
    drain();
    set_camera(prdg_pkg::BASIS_U_RST, prdg_pkg::BASIS_V_RST, prdg_pkg::BASIS_W_RST,
               16'd0, 16'd1, 16'hFFFF, 13'd4096, 13'h1FFF);
    queue_pixel(2047, 4095);
    queue_pixel(2048, 0);
    drain();

    // Random phases with fresh camera setups between them.
    for (int phase = 0; phase < 10; phase++) begin
      logic [COUNT_W-1:0] cols, rws;
      cols = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 8191))
                                         : COUNT_W'($urandom_range(1, 4096));
      rws  = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 8191))
                                         : COUNT_W'($urandom_range(1, 64));
      set_camera(rand_basis(), rand_basis(), rand_basis(),
                 PLANE_W'($urandom_range(0, 65535)), PLANE_W'($urandom_range(0, 65535)),
                 PLANE_W'($urandom_range(0, 65535)), cols, rws);
      queue_random_pixels(80);
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- primary_ray_direction_generator_core.f -----
src/prdg_pkg.sv
src/prdg_div_pipe.sv
src/prdg_isqrt_pipe.sv
src/primary_ray_direction_generator_core.sv
bench/primary_ray_direction_generator_core_test.sv
